FILE: sv/frame_time_stats_histogram_assert.svh
// Assertion macros for the frame-time statistics block.
// Included by modules that check their own sequencing; needs nothing else.
`ifndef FRAME_TIME_STATS_HISTOGRAM_ASSERT_SVH
`define FRAME_TIME_STATS_HISTOGRAM_ASSERT_SVH

// Condition that must hold at every edge outside reset
`define FTS_CHECK(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("fts check failed");

// Same-cycle implication
`define FTS_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fts implication failed");

// Next-cycle implication
`define FTS_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fts sequence failed");

`endif

FILE: sv/fts_pkg.sv
// Shared types, codes and helpers for the frame-time statistics block.
// Used by fts_walk, fts_core and the top module; depends on nothing.
`timescale 1ns / 1ps

package fts_pkg;

   // Command codes carried in the item
   localparam logic [1:0] CMD_RECORD   = 2'd0;
   localparam logic [1:0] CMD_SNAPSHOT = 2'd1;
   localparam logic [1:0] CMD_CLEAR    = 2'd2;

   // Register indexes and register reset values
   localparam int         CSR_IDX_W    = 1;
   localparam int         CSR_DATA_W   = 16;
   localparam logic [0:0] CSR_BUDGET   = 1'd0;
   localparam logic [0:0] CSR_PCT      = 1'd1;
   localparam logic [15:0] BUDGET_RESET = 16'd33;
   localparam logic [6:0]  PCT_RESET    = 7'd95;

   // Percentile scale and the width of frames * pct
   localparam logic [6:0] PCT_SCALE = 7'd100;
   localparam int         TARGET_W  = 39;

   typedef logic [5:0] p95_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] frame_ms;
      logic [23:0] frame_pixels;
   } req_type;

   typedef struct packed {
      logic [31:0] frames_logged;
      logic [47:0] pixel_total;
      logic [15:0] max_ms;
      logic [31:0] late_count;
      logic [31:0] late_streak_max;
      p95_type     p95_ms;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLR  = 5'b00001,
      ST_IDLE = 5'b00010,
      ST_REC  = 5'b00100,
      ST_WALK = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   // Sequencer to walk unit
   typedef struct packed {
      logic start;
      logic step;
   } walk_ctl_type;

   // Walk unit to sequencer
   typedef struct packed {
      logic busy;
      logic hit;
   } walk_sts_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      return (&v) ? v : v + 32'd1;
   endfunction

endpackage

FILE: sv/fts_hist_ram.sv
// Histogram bucket memory: one write port, one registered read port.
// Stand-alone storage; depends on nothing.
`timescale 1ns / 1ps

module fts_hist_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem_ff [DEPTH];
   logic [31:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/fts_walk.sv
// Percentile walk unit: scales each bucket count by 100, accumulates and
// compares against frames * pct. Depends on fts_pkg.
`timescale 1ns / 1ps

module fts_walk #(
   parameter int AW = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fts_pkg::walk_ctl_type         ctl,
   input  logic [31:0]                   step_count,
   input  logic [AW-1:0]                 step_idx,
   input  logic [fts_pkg::TARGET_W-1:0]  target,
   output fts_pkg::walk_sts_type         sts,
   output logic [AW-1:0]                 hit_idx
);

   // Cumulative scaled count stays below BUCKETS * 2^39
   localparam int ACC_W = fts_pkg::TARGET_W + AW;

   logic [fts_pkg::TARGET_W-1:0] scaled_ff, scaled_in;
   logic [AW-1:0]                idx_ff;
   logic                         vld_ff, vld_in;
   logic [ACC_W-1:0]             acc_ff, acc_in, acc_sum;
   logic                         hit_ff, hit_in;
   logic [AW-1:0]                hit_idx_ff;

   // Scale stage, then accumulate and compare stage
   always_comb begin
      scaled_in = fts_pkg::TARGET_W'(step_count) * fts_pkg::TARGET_W'(fts_pkg::PCT_SCALE);
      vld_in    = ctl.step & ~ctl.start;
      acc_sum   = acc_ff + ACC_W'(scaled_ff);
      if (ctl.start) begin
         acc_in = '0;
      end else if (vld_ff) begin
         acc_in = acc_sum;
      end else begin
         acc_in = acc_ff;
      end
      hit_in = ~ctl.start & vld_ff & (acc_sum >= ACC_W'(target));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      scaled_ff  <= scaled_in;
      idx_ff     <= step_idx;
      acc_ff     <= acc_in;
      hit_idx_ff <= idx_ff;
   end

   assign sts.busy = vld_ff;
   assign sts.hit  = hit_ff;
   assign hit_idx  = hit_idx_ff;

endmodule

FILE: sv/fts_core.sv
// Sequencer and statistics registers: record, clear sweep, percentile walk
// and the result register. Depends on fts_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "frame_time_stats_histogram_assert.svh"

module fts_core #(
   parameter int BUCKETS = 64,
   parameter int AW      = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fts_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fts_pkg::rsp_type              rsp_data,
   input  logic [15:0]                   budget,
   input  logic [6:0]                    pct,
   output logic                          ram_wr_en,
   output logic [AW-1:0]                 ram_wr_addr,
   output logic [31:0]                   ram_wr_data,
   output logic                          ram_rd_en,
   output logic [AW-1:0]                 ram_rd_addr,
   input  logic [31:0]                   ram_rd_data,
   output fts_pkg::walk_ctl_type         walk_ctl,
   output logic [AW-1:0]                 walk_idx,
   output logic [fts_pkg::TARGET_W-1:0]  walk_target,
   input  fts_pkg::walk_sts_type         walk_sts,
   input  logic [AW-1:0]                 walk_hit_idx
);

   fts_pkg::state_type state_ff, state_in;
   logic [AW:0]        cnt_ff, cnt_in;
   logic [AW-1:0]      bin_ff, bin_in;
   logic [15:0]        time_ff, time_in;
   logic [23:0]        px_ff, px_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic [fts_pkg::TARGET_W-1:0] target_ff, target_in;
   fts_pkg::p95_type   p95_ff, p95_in;

   logic [31:0] frames_ff, frames_in;
   logic [47:0] pixels_ff, pixels_in;
   logic [15:0] longest_ff, longest_in;
   logic [31:0] late_ff, late_in;
   logic [31:0] run_ff, run_in;
   logic [31:0] run_max_ff, run_max_in;

   logic             rsp_valid_ff, rsp_valid_in;
   fts_pkg::rsp_type rsp_ff, rsp_in;

   logic        accept;
   logic        walk_rd;
   logic        rsp_load;
   logic [48:0] pixel_add;
   logic [31:0] run_next;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != fts_pkg::ST_IDLE);
   assign walk_rd   = (state_ff == fts_pkg::ST_WALK) && (cnt_ff < (AW+1)'(BUCKETS));
   assign rsp_load  = (state_ff == fts_pkg::ST_DONE) && (~rsp_valid_ff | ~rsp_stall);

   // Clamp the frame time to the last bucket
   always_comb begin
      if (32'(req_data.frame_ms) < 32'(BUCKETS - 1)) begin
         bin_in = AW'(req_data.frame_ms);
      end else begin
         bin_in = AW'(BUCKETS - 1);
      end
   end

   // Memory ports
   always_comb begin
      ram_rd_en   = (accept && req_data.cmd == fts_pkg::CMD_RECORD) || walk_rd;
      ram_rd_addr = (state_ff == fts_pkg::ST_WALK) ? cnt_ff[AW-1:0] : bin_in;
      ram_wr_en   = (state_ff == fts_pkg::ST_CLR) || (state_ff == fts_pkg::ST_REC);
      if (state_ff == fts_pkg::ST_CLR) begin
         ram_wr_addr = cnt_ff[AW-1:0];
         ram_wr_data = '0;
      end else begin
         ram_wr_addr = bin_ff;
         ram_wr_data = fts_pkg::sat_inc32(ram_rd_data);
      end
   end

   // Walk unit feed
   assign walk_ctl.start = accept && (req_data.cmd == fts_pkg::CMD_SNAPSHOT);
   assign walk_ctl.step  = rd_vld_ff && (state_ff == fts_pkg::ST_WALK);
   assign walk_idx       = rd_idx_ff;
   assign walk_target    = target_ff;

   // Sequencer and statistics update
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      time_in    = time_ff;
      px_in      = px_ff;
      target_in  = target_ff;
      p95_in     = p95_ff;
      frames_in  = frames_ff;
      pixels_in  = pixels_ff;
      longest_in = longest_ff;
      late_in    = late_ff;
      run_in     = run_ff;
      run_max_in = run_max_ff;
      rd_vld_in  = walk_rd;
      rd_idx_in  = cnt_ff[AW-1:0];
      pixel_add  = {1'b0, pixels_ff} + 49'(px_ff);
      run_next   = fts_pkg::sat_inc32(run_ff);

      unique case (state_ff)
         fts_pkg::ST_CLR: begin
            // Sweep the histogram to zero, one bucket a cycle
            if (cnt_ff == (AW+1)'(BUCKETS - 1)) begin
               state_in = fts_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + (AW+1)'(1);
            end
         end
         fts_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.cmd)
                  fts_pkg::CMD_RECORD: begin
                     time_in  = req_data.frame_ms;
                     px_in    = req_data.frame_pixels;
                     state_in = fts_pkg::ST_REC;
                  end
                  fts_pkg::CMD_SNAPSHOT: begin
                     // rank reached when 100 * cum >= frames * pct
                     target_in = fts_pkg::TARGET_W'(frames_ff) * fts_pkg::TARGET_W'(pct);
                     cnt_in    = '0;
                     p95_in    = '0;
                     // No frames: every statistic is still zero
                     state_in  = (frames_ff == '0) ? fts_pkg::ST_DONE : fts_pkg::ST_WALK;
                  end
                  fts_pkg::CMD_CLEAR: begin
                     frames_in  = '0;
                     pixels_in  = '0;
                     longest_in = '0;
                     late_in    = '0;
                     run_in     = '0;
                     run_max_in = '0;
                     cnt_in     = '0;
                     state_in   = fts_pkg::ST_CLR;
                  end
                  default: begin
                     // unused command: drop the item
                  end
               endcase
            end
         end
         fts_pkg::ST_REC: begin
            frames_in = fts_pkg::sat_inc32(frames_ff);
            pixels_in = pixel_add[48] ? '1 : pixel_add[47:0];
            if (time_ff > longest_ff) begin
               longest_in = time_ff;
            end
            if (time_ff > budget) begin
               late_in = fts_pkg::sat_inc32(late_ff);
               run_in  = run_next;
               if (run_next > run_max_ff) begin
                  run_max_in = run_next;
               end
            end else begin
               run_in = '0;
            end
            state_in = fts_pkg::ST_IDLE;
         end
         fts_pkg::ST_WALK: begin
            if (walk_rd) begin
               cnt_in = cnt_ff + (AW+1)'(1);
            end
            priority if (walk_sts.hit) begin
               p95_in   = fts_pkg::p95_type'(walk_hit_idx);
               state_in = fts_pkg::ST_DONE;
            end else if (!walk_rd && !rd_vld_ff && !walk_sts.busy) begin
               // rank never reached
               p95_in   = '0;
               state_in = fts_pkg::ST_DONE;
            end
         end
         fts_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = fts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fts_pkg::ST_CLR;
            cnt_in   = '0;
         end
      endcase
   end

   // Result register: load on finish, hold while stalled
   always_comb begin
      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_in.frames_logged   = frames_ff;
         rsp_in.pixel_total     = pixels_ff;
         rsp_in.max_ms          = longest_ff;
         rsp_in.late_count      = late_ff;
         rsp_in.late_streak_max = run_max_ff;
         rsp_in.p95_ms          = p95_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fts_pkg::ST_CLR;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         frames_ff    <= '0;
         pixels_ff    <= '0;
         longest_ff   <= '0;
         late_ff      <= '0;
         run_ff       <= '0;
         run_max_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         frames_ff    <= frames_in;
         pixels_ff    <= pixels_in;
         longest_ff   <= longest_in;
         late_ff      <= late_in;
         run_ff       <= run_in;
         run_max_ff   <= run_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff    <= (accept) ? bin_in : bin_ff;
      time_ff   <= time_in;
      px_ff     <= px_in;
      rd_idx_ff <= rd_idx_in;
      target_ff <= target_in;
      p95_ff    <= p95_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `FTS_CHECK(a_run_le_max, clock, reset, run_ff <= run_max_ff)
   `FTS_CHECK(a_late_le_frames, clock, reset, late_ff <= frames_ff)
   `FTS_NEXT(a_rec_follows, clock, reset,
             accept && req_data.cmd == fts_pkg::CMD_RECORD,
             state_ff == fts_pkg::ST_REC)
   `FTS_IMPLY(a_walk_no_wr, clock, reset, state_ff == fts_pkg::ST_WALK, !ram_wr_en)
   `FTS_NEXT(a_done_loads, clock, reset, rsp_load,
             rsp_valid_ff && state_ff == fts_pkg::ST_IDLE)

endmodule

FILE: sv/frame_time_stats_histogram.sv
// Frame-time statistics with a BUCKETS-entry histogram and a percentile query.
// A record item reads its histogram bucket, then writes back the incremented
// bucket together with the counter updates. A snapshot item skips the walk
// when no frames are recorded; otherwise the walk reads one bucket per cycle
// through the scale-accumulate-compare unit until the bucket where the
// percentile lands is found or every bucket is read. A clear item, and the
// clearing pass after reset, sweep the histogram one bucket per cycle, during
// which no item is accepted; register writes are taken at any time. An unused
// command is taken and dropped. The result register lets a new item in while
// a snapshot result waits to be taken.
// Depends on fts_pkg, fts_hist_ram, fts_walk and fts_core.
`timescale 1ns / 1ps

module frame_time_stats_histogram #(
   parameter int BUCKETS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  fts_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output fts_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(BUCKETS);

   logic [15:0] budget_ff, budget_in;
   logic [6:0]  pct_ff, pct_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [31:0]   ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [31:0]   ram_rd_data;

   fts_pkg::walk_ctl_type        walk_ctl;
   fts_pkg::walk_sts_type        walk_sts;
   logic [AW-1:0]                walk_idx;
   logic [AW-1:0]                walk_hit_idx;
   logic [fts_pkg::TARGET_W-1:0] walk_target;

   // Register writes
   assign csr_ready = 1'b1;

   always_comb begin
      budget_in = budget_ff;
      pct_in    = pct_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fts_pkg::CSR_BUDGET: budget_in = csr_wdata;
            fts_pkg::CSR_PCT:    pct_in    = csr_wdata[6:0];
            default: begin
               // no register at this index
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= fts_pkg::BUDGET_RESET;
         pct_ff    <= fts_pkg::PCT_RESET;
      end else begin
         budget_ff <= budget_in;
         pct_ff    <= pct_in;
      end
   end

   fts_hist_ram #(
      .DEPTH (BUCKETS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fts_walk #(
      .AW (AW)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .ctl        (walk_ctl),
      .step_count (ram_rd_data),
      .step_idx   (walk_idx),
      .target     (walk_target),
      .sts        (walk_sts),
      .hit_idx    (walk_hit_idx)
   );

   fts_core #(
      .BUCKETS (BUCKETS),
      .AW      (AW)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .budget       (budget_ff),
      .pct          (pct_ff),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .walk_ctl     (walk_ctl),
      .walk_idx     (walk_idx),
      .walk_target  (walk_target),
      .walk_sts     (walk_sts),
      .walk_hit_idx (walk_hit_idx)
   );

endmodule
